// File: rtl/psmq_pkg.sv
`timescale 1ns / 1ps

package psmq_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int KEY_W = 32;
  localparam int BEST_W = 33;

  // One table entry: key ascending, best strictly descending along the row.
  typedef struct packed {
    logic signed [KEY_W-1:0]  key;
    logic signed [BEST_W-1:0] best;
  } entry_t;

  // Operands broadcast to every cell when an item is accepted.
  typedef struct packed {
    logic signed [KEY_W-1:0]  key;
    logic signed [BEST_W-1:0] total;
  } bcast_t;

  // Per-cycle command from the controller to the row of cells.
  typedef struct packed {
    logic load;      // latch compare flags against the broadcast operands
    logic ins_open;  // insert that removes nothing: open a slot by shifting right
    logic ins_move;  // insert that overwrites the first removed entry
    logic compact;   // close one hole by shifting left
  } ctl_t;

  // Status that each cell reports to the controller and its right neighbor.
  typedef struct packed {
    logic ltv;         // valid entry with a key below the broadcast key
    logic keep;        // entry survives an insert and stays left of it
    logic rmeq;        // entry is removed by the insert
    logic dom;         // entry at or above the key dominates the new point
    logic first;       // first valid entry at or above the key
    logic hole;        // entry is currently a hole waiting for compaction
    logic hole_new;    // entry becomes a hole after an overwriting insert
    logic hole_shift;  // hole bit after the next compaction step
  } cell_stat_t;

endpackage

// File: rtl/psmq_cell.sv
`timescale 1ns / 1ps

module psmq_cell
  import psmq_pkg::*;
(
  input  logic       clk,
  input  ctl_t       ctl,
  input  bcast_t     bc,
  input  entry_t     new_ent,
  input  logic       valid_in,
  input  logic       left_ltv,
  input  logic       left_keep,
  input  entry_t     left_ent,
  input  entry_t     right_ent,
  input  logic       right_hole,
  output entry_t     ent,
  output cell_stat_t stat
);

  logic vld;
  logic ltv;
  logic eqv;
  logic le;
  logic ge;
  logic hole;
  logic sh;
  logic keep;
  logic pos;
  logic start_slot;

  always_comb begin
    keep            = ltv & ~le;
    pos             = ~ltv & left_ltv;
    start_slot      = ~keep & left_keep;
    stat.ltv        = ltv;
    stat.keep       = keep;
    stat.rmeq       = (ltv & le) | eqv;
    stat.dom        = vld & ~ltv & ge;
    stat.first      = vld & ~ltv & left_ltv;
    stat.hole       = hole;
    stat.hole_new   = stat.rmeq & ~start_slot;
    stat.hole_shift = sh ? right_hole : hole;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      vld <= valid_in;
      ltv <= valid_in & (ent.key < bc.key);
      eqv <= valid_in & (ent.key == bc.key);
      le  <= ent.best <= bc.total;
      ge  <= ent.best >= bc.total;
    end else if (ctl.ins_open) begin
      if (pos) begin
        ent <= new_ent;
      end else if (!ltv) begin
        ent <= left_ent;
      end
    end else if (ctl.ins_move) begin
      if (start_slot) begin
        ent <= new_ent;
      end
      hole <= stat.hole_new;
      sh   <= ~keep & ~start_slot;
    end else if (ctl.compact) begin
      if (sh) begin
        ent  <= right_ent;
        hole <= right_hole;
      end
    end
  end

endmodule

// File: rtl/pareto_staircase_max_query.sv
`timescale 1ns / 1ps

// Staircase table for dominance max queries.
//
// Command channel: an item transfers at a rising edge where start is high and
// busy is low. command 0 inserts the point (point_x, point_y) with key point_y
// and sum point_x + point_y; command 1 queries the table with bound_y. The
// feeder orders points and queries by x so that every point with x at or above
// a query's x bound is inserted before that query.
//
// Result channel: exactly one result per item. done is high for one cycle and
// the result transfers at the edge that ends that cycle; the receiver cannot
// stall it. found and best_sum carry query results (best_sum is -1 when no key
// reaches the bound), table_full flags an insert dropped for lack of space.
//
// Sequence: done is registered from S_DECIDE; the result transfers at the
// edge that ends the done cycle. The row of cells compares every entry at
// the accepting edge and the decision and update follow in S_DECIDE, which
// ends a query or an insert that removes at most one entry. An insert that
// removes r > 1 entries closes its r - 1 holes in S_COMPACT, one left shift
// of the row per cycle, so removals are bounded by the earlier inserts.
// Reset empties the table at once; entry contents need no clearing.
module pareto_staircase_max_query
  import psmq_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     command,
  input  logic signed [KEY_W-1:0]  point_x,
  input  logic signed [KEY_W-1:0]  point_y,
  input  logic signed [KEY_W-1:0]  bound_y,
  output logic                     done,
  output logic                     found,
  output logic signed [BEST_W-1:0] best_sum,
  output logic                     table_full
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE    = 3'b001,
    S_DECIDE  = 3'b010,
    S_COMPACT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             cmd_q;
  entry_t           ins_ent;

  bcast_t     bc;
  ctl_t       ctl;
  entry_t     ent      [TABLE_DEPTH];
  cell_stat_t stat     [TABLE_DEPTH];
  logic       valid_vec[TABLE_DEPTH];

  logic                     accept;
  logic                     any_dom;
  logic                     any_rmeq;
  logic                     any_hole_new;
  logic                     any_hole_shift;
  logic                     any_first;
  logic signed [BEST_W-1:0] sel_best;
  logic                     nothing_removed;
  logic                     full_now;
  logic                     do_ins;

  assign busy   = (state != S_IDLE);
  assign accept = start & ~busy;

  // The comparison key is the point's y for an insert and the bound for a query.
  always_comb begin
    bc.key   = command ? bound_y : point_y;
    bc.total = BEST_W'(point_x) + BEST_W'(point_y);
  end

  // The row of cells. Each cell sees its left and right neighbors only.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic   l_ltv;
    logic   l_keep;
    entry_t l_ent;
    entry_t r_ent;
    logic   r_hole;

    assign valid_vec[i] = (CNT_W'(i) < count);

    if (i == 0) begin : g_left_edge
      assign l_ltv  = 1'b1;
      assign l_keep = 1'b1;
      assign l_ent  = ent[0];
    end else begin : g_left
      assign l_ltv  = stat[i-1].ltv;
      assign l_keep = stat[i-1].keep;
      assign l_ent  = ent[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_right_edge
      assign r_ent  = ent[i];
      assign r_hole = 1'b0;
    end else begin : g_right
      assign r_ent  = ent[i+1];
      assign r_hole = stat[i+1].hole;
    end

    psmq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .bc         (bc),
      .new_ent    (ins_ent),
      .valid_in   (valid_vec[i]),
      .left_ltv   (l_ltv),
      .left_keep  (l_keep),
      .left_ent   (l_ent),
      .right_ent  (r_ent),
      .right_hole (r_hole),
      .ent        (ent[i]),
      .stat       (stat[i])
    );
  end

  // Reductions across the row. The first-at-or-above flag is one-hot, so the
  // query result is an AND-OR select.
  always_comb begin
    any_dom        = 1'b0;
    any_rmeq       = 1'b0;
    any_hole_new   = 1'b0;
    any_hole_shift = 1'b0;
    any_first      = 1'b0;
    sel_best       = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      any_dom        = any_dom | stat[i].dom;
      any_rmeq       = any_rmeq | stat[i].rmeq;
      any_hole_new   = any_hole_new | stat[i].hole_new;
      any_hole_shift = any_hole_shift | stat[i].hole_shift;
      any_first      = any_first | stat[i].first;
      sel_best       = sel_best | (stat[i].first ? ent[i].best : '0);
    end
  end

  // An insert that dominates nothing and is not dominated needs a free slot.
  always_comb begin
    nothing_removed = ~any_rmeq;
    full_now        = nothing_removed & (count == CNT_W'(TABLE_DEPTH));
    do_ins          = ~cmd_q & ~any_dom & ~full_now;
  end

  always_comb begin
    ctl.load     = accept;
    ctl.ins_open = (state == S_DECIDE) & do_ins & nothing_removed;
    ctl.ins_move = (state == S_DECIDE) & do_ins & ~nothing_removed;
    ctl.compact  = (state == S_COMPACT);
  end

  always_comb begin
    state_next = state;
    count_next = count;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (ctl.ins_open) begin
          count_next = count + 1'b1;
        end
        if (ctl.ins_move && any_hole_new) begin
          state_next = S_COMPACT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_COMPACT: begin
        count_next = count - 1'b1;
        if (!any_hole_shift) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= (state == S_DECIDE);
    end
  end

  // Item operands and the found, best_sum and table_full registers carry no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q        <= command;
      ins_ent.key  <= point_y;
      ins_ent.best <= bc.total;
    end
    if (state == S_DECIDE) begin
      found      <= cmd_q & any_first;
      best_sum   <= cmd_q ? (any_first ? sel_best : '1) : '0;
      table_full <= ~cmd_q & ~any_dom & full_now;
    end
  end

  a_done_after_decide : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_DECIDE))
    else $error("result strobe without a decide cycle");

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_compact_shrinks : assert property (@(posedge clk) disable iff (rst)
    state == S_COMPACT |=> count == $past(count) - 1'b1)
    else $error("compaction step did not remove an entry");

  a_full_only_when_full : assert property (@(posedge clk) disable iff (rst)
    done && table_full |-> count == CNT_W'(TABLE_DEPTH) && !found)
    else $error("insert flagged full while space remained");

endmodule

// File: sim/psmq_staircase_checker.sv
`timescale 1ns / 1ps

package psmq_test_pkg;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_QUERY  = 1'b1
  } psmq_cmd_e;

endpackage

module psmq_staircase_checker
  import psmq_pkg::*;
  import psmq_test_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     busy,
  input  logic                     command,
  input  logic signed [KEY_W-1:0]  point_x,
  input  logic signed [KEY_W-1:0]  point_y,
  input  logic signed [KEY_W-1:0]  bound_y,
  input  logic                     done,
  input  logic                     found,
  input  logic signed [BEST_W-1:0] best_sum,
  input  logic                     table_full,
  output int                       mismatches,
  output int                       pending
);

  localparam logic signed [BEST_W-1:0] NO_BEST = -1;

  typedef struct packed {
    logic                     found;
    logic signed [BEST_W-1:0] best_sum;
    logic                     table_full;
  } outcome_t;

  // Shadow of the staircase: keys ascending, bests strictly descending.
  logic signed [KEY_W-1:0]  stair_key [DEPTH];
  logic signed [BEST_W-1:0] stair_best [DEPTH];
  int                       stair_len;
  outcome_t                 awaited_outcomes[$];

  initial begin
    mismatches = 0;
    pending = 0;
    stair_len = 0;
  end

  function automatic int first_reaching(input logic signed [KEY_W-1:0] k);
    int i;
    i = 0;
    while (i < stair_len && stair_key[i] < k) i++;
    return i;
  endfunction

  task automatic place_point(input logic signed [KEY_W-1:0] y,
                             input logic signed [BEST_W-1:0] total,
                             output logic dropped_full);
    int pos;
    int eq;
    int after;
    int k;
    int head;
    int new_len;
    int i;
    dropped_full = 1'b0;
    pos = first_reaching(y);
    eq = 0;
    if (pos < stair_len && stair_key[pos] == y) begin
      if (stair_best[pos] >= total) return;
      eq = 1;
    end
    after = pos + eq;
    if (after < stair_len && stair_best[after] >= total) return;
    k = 0;
    while (k < pos && stair_best[pos-1-k] <= total) k++;
    new_len = stair_len - eq - k + 1;
    // A full table rejects the point before anything is removed.
    if (new_len > DEPTH) begin
      dropped_full = 1'b1;
      return;
    end
    head = pos - k;
    if (head + 1 <= after) begin
      for (i = 0; i < stair_len - after; i++) begin
        stair_key[head+1+i] = stair_key[after+i];
        stair_best[head+1+i] = stair_best[after+i];
      end
    end else begin
      for (i = stair_len - after - 1; i >= 0; i--) begin
        stair_key[head+1+i] = stair_key[after+i];
        stair_best[head+1+i] = stair_best[after+i];
      end
    end
    stair_key[head] = y;
    stair_best[head] = total;
    stair_len = new_len;
  endtask

  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    logic signed [BEST_W-1:0] total;
    logic full;
    int idx;
    if (rst) begin
      stair_len = 0;
      awaited_outcomes.delete();
      pending <= 0;
    end else begin
      if (done) begin
        got = '{found, best_sum, table_full};
        if (awaited_outcomes.size() == 0) begin
          $error("result transfer with no item outstanding");
          mismatches++;
        end else begin
          want = awaited_outcomes.pop_front();
          if (got.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            mismatches++;
          end
          if (got.best_sum !== want.best_sum) begin
            $error("best_sum: expected %0d, got %0d", want.best_sum, got.best_sum);
            mismatches++;
          end
          if (got.table_full !== want.table_full) begin
            $error("table_full: expected %0d, got %0d", want.table_full, got.table_full);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        if (command == CMD_QUERY) begin
          idx = first_reaching(bound_y);
          want.found = (idx < stair_len);
          want.best_sum = (idx < stair_len) ? stair_best[idx] : NO_BEST;
          want.table_full = 1'b0;
        end else begin
          total = point_x + point_y;
          place_point(point_y, total, full);
          want.found = 1'b0;
          want.best_sum = '0;
          want.table_full = full;
        end
        awaited_outcomes.push_back(want);
      end
      pending <= awaited_outcomes.size();
    end
  end

endmodule

// File: sim/pareto_staircase_max_query_test.sv
`timescale 1ns / 1ps

// Top of the staircase testbench. This module only produces stimulus and
// gives the verdict; the checker beside the block predicts every result and
// counts mismatches.
module pareto_staircase_max_query_test;
  import psmq_pkg::*;
  import psmq_test_pkg::*;

  localparam longint KEY_MIN = -64'sd2147483648;
  localparam longint KEY_MAX = 64'sd2147483647;
  localparam int RANDOM_ITEMS = 1000;
  localparam int CYCLE_LIMIT = 1000000;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic                     command;
  logic signed [KEY_W-1:0]  point_x;
  logic signed [KEY_W-1:0]  point_y;
  logic signed [KEY_W-1:0]  bound_y;
  logic                     done;
  logic                     found;
  logic signed [BEST_W-1:0] best_sum;
  logic                     table_full;
  int                       mismatches;
  int                       pending;
  int                       cycle_count;

  // Stimulus bookkeeping. key_ceiling is the highest key of any point inserted;
  // a run of points with keys above it lands in the table while space remains,
  // which is how the table is kept deep even after strong points have shown up.
  int     items_sent;
  int     burst_left;
  longint key_ceiling;
  longint recent_key[$];
  longint recent_total[$];

  pareto_staircase_max_query i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .command    (command),
    .point_x    (point_x),
    .point_y    (point_y),
    .bound_y    (bound_y),
    .done       (done),
    .found      (found),
    .best_sum   (best_sum),
    .table_full (table_full)
  );

  psmq_staircase_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .command    (command),
    .point_x    (point_x),
    .point_y    (point_y),
    .bound_y    (bound_y),
    .done       (done),
    .found      (found),
    .best_sum   (best_sum),
    .table_full (table_full),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("pareto_staircase_max_query_test failed");
      $finish;
    end
  end

  function automatic longint rand_word();
    return longint'($signed($urandom));
  endfunction

  // Uniform value in [lo, hi]; the span may be the full 32-bit range.
  function automatic longint rand_between(input longint lo, input longint hi);
    logic [63:0]     r;
    longint unsigned span;
    r = {$urandom, $urandom};
    span = longint'(hi - lo + 1);
    return lo + longint'(r % span);
  endfunction

  function automatic longint clamp_word(input longint v);
    if (v < KEY_MIN) return KEY_MIN;
    if (v > KEY_MAX) return KEY_MAX;
    return v;
  endfunction

  // Presents one item and holds it until the block takes it. Returns at the
  // edge of the transfer. The sender then either presents the next item in
  // the same step, keeping start high, or drops start for a random gap once
  // its current burst is used up.
  task automatic transfer(input psmq_cmd_e cmd, input longint x, input longint y,
                          input longint b);
    start <= 1'b1;
    command <= cmd;
    point_x <= x[31:0];
    point_y <= y[31:0];
    bound_y <= b[31:0];
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    items_sent++;
    if (cmd == CMD_INSERT) begin
      if (y > key_ceiling) key_ceiling = y;
      recent_key.push_back(y);
      recent_total.push_back(x + y);
      if (recent_key.size() > 16) begin
        void'(recent_key.pop_front());
        void'(recent_total.pop_front());
      end
    end
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      // Now and then a long burst, so that stretches without gaps occur.
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
  endtask

  task automatic insert(input longint x, input longint y);
    transfer(CMD_INSERT, x, y, rand_word());
  endtask

  task automatic query(input longint b);
    transfer(CMD_QUERY, rand_word(), rand_word(), b);
  endtask

  // Holds the sender off until every outstanding result has arrived. The
  // first edge lets the count from the last transfer become visible.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // A run of points with keys rising above everything sent so far. With
  // falling sums every point becomes a new step, so a long run fills the
  // table and the tail of it is rejected for lack of space. With sums that
  // may rise, later points sweep away earlier ones from the same run.
  task automatic insert_staircase(input int len, input bit falling);
    longint dy;
    longint dx;
    longint x0;
    longint y0;
    int     j;
    dy = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 1 << 23);
    if (key_ceiling + longint'(len + 1) * dy > KEY_MAX)
      dy = (KEY_MAX - key_ceiling) / (len + 1);
    if (dy == 0) return;
    if (falling) begin
      dx = dy + $urandom_range(1, 64);
    end else begin
      dx = dy + int'($urandom_range(0, 64)) - 16;
      if (dx < 0) dx = 0;
    end
    x0 = rand_between(KEY_MIN + longint'(len) * dx, KEY_MAX);
    y0 = key_ceiling + dy;
    for (j = 0; j < len; j++) insert(x0 - j * dx, y0 + j * dy);
  endtask

  // A point close to one sent recently: same key, or a neighbor, with a sum
  // a little above or below. This is where equal keys, ties and dominance
  // by the next step show up.
  task automatic insert_near_recent();
    int     idx;
    longint y;
    longint total;
    if (recent_key.size() == 0) begin
      insert(rand_word(), rand_between(KEY_MIN, key_ceiling));
      return;
    end
    idx = $urandom_range(0, recent_key.size() - 1);
    y = clamp_word(recent_key[idx] + int'($urandom_range(0, 2)) - 1);
    total = recent_total[idx] + int'($urandom_range(0, 6)) - 3;
    insert(clamp_word(total - y), y);
  endtask

  task automatic query_random();
    int pick;
    int idx;
    pick = $urandom_range(0, 2);
    if (pick == 0 || recent_key.size() == 0) begin
      query(rand_word());
    end else if (pick == 1) begin
      idx = $urandom_range(0, recent_key.size() - 1);
      query(clamp_word(recent_key[idx] + int'($urandom_range(0, 2)) - 1));
    end else begin
      query(rand_between(KEY_MIN, clamp_word(key_ceiling + 1)));
    end
  endtask

  initial begin
    int choice;
    int goal;
    rst = 1'b1;
    start = 1'b0;
    command = CMD_INSERT;
    point_x = '0;
    point_y = '0;
    bound_y = '0;
    items_sent = 0;
    burst_left = 4;
    key_ceiling = KEY_MIN;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. The table starts empty, so queries first see nothing.
    query(0);
    query(KEY_MIN);
    // The lowest key with the lowest possible sum, then replaced in place
    // by a larger sum, then a smaller sum on the same key that is dropped.
    insert(KEY_MIN, KEY_MIN);
    query(KEY_MIN);
    query(KEY_MIN + 1);
    insert(KEY_MAX, KEY_MIN);
    insert(-5, KEY_MIN);
    // Build a short staircase, with one point dominated by the step above.
    insert(50, -100);
    insert(-100, -200);
    insert(-10, -50);
    insert(-50, -20);
    // One point above all steps that removes every one of them at once.
    insert(20, -10);
    query(-10);
    query(-9);
    query(-11);
    // Ties: equal sum below a step and equal sum on the same key are dropped.
    insert(40, -30);
    insert(20, -10);
    insert(21, -10);
    insert(52, -40);
    insert(31, -20);
    // Equal sum to the step below it: that step is removed.
    insert(32, -20);
    query(-40);
    query(-15);

    // The sender waits for the block to drain completely at least once.
    wait_drained();

    // Random part. Open with a run long enough to fill the table.
    goal = items_sent + RANDOM_ITEMS;
    insert_staircase(68, 1'b1);
    while (items_sent < goal) begin
      choice = $urandom_range(0, 99);
      if (choice < 12) begin
        if ($urandom_range(0, 9) == 0) insert_staircase($urandom_range(60, 72), 1'b1);
        else insert_staircase($urandom_range(2, 10), $urandom_range(0, 1));
      end else if (choice < 35) begin
        insert_near_recent();
      end else if (choice < 50) begin
        insert(rand_word(), rand_between(KEY_MIN, key_ceiling));
      end else if (choice < 98) begin
        query_random();
      end else begin
        wait_drained();
      end
    end

    // Points at the very top of the range go last: a point with the largest
    // key and sum dominates everything and would freeze the table.
    query(KEY_MAX);
    insert(KEY_MAX, KEY_MAX);
    query(KEY_MAX);
    query(KEY_MIN);
    insert(KEY_MIN, KEY_MIN);
    insert(KEY_MAX, KEY_MAX);
    query(0);

    // Let the last results arrive, then keep the clock running in case the block
    // produces something it should not.
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("pareto_staircase_max_query_test passed");
    end else begin
      $display("pareto_staircase_max_query_test failed");
    end
    $finish;
  end

endmodule
